// File: design/dmv_pkg.sv
// shared types and constants of the dao message validator
package dmv_pkg;

	typedef struct packed {
		logic [7:0] msg_byte;
		logic       final_byte;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [7:0]  instance_id;
		logic        ack_wanted;
		logic        id_present;
		logic [7:0]  sequence_number;
		logic [63:0] dodag_id_high;
		logic [63:0] dodag_id_low;
	} out_item_t;

	typedef struct packed {
		logic        active;
		logic        too_short;
		logic        id_short;
		logic        reserved_fault;
		logic [7:0]  instance_id;
		logic        ack_flag;
		logic        id_flag;
		logic [7:0]  sequence_number;
		logic [63:0] dodag_upper;
		logic [63:0] dodag_lower;
	} hdr_info_t;

	typedef struct packed {
		logic fault;
		logic open_option;
	} opt_info_t;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_TOO_SHORT = 2'd1;
	localparam logic [1:0] ST_BAD       = 2'd2;

	localparam logic [4:0] HDR_SHORT = 5'd4;
	localparam logic [4:0] HDR_UPPER = 5'd12;
	localparam logic [4:0] HDR_LONG  = 5'd20;

	localparam logic [7:0] TYPE_PAD1       = 8'd0;
	localparam logic [7:0] TYPE_TARGET     = 8'd5;
	localparam logic [7:0] TYPE_TRANSIT    = 8'd6;
	localparam logic [7:0] TYPE_DESCRIPTOR = 8'd9;

	localparam logic [7:0] LEN_TARGET     = 8'd18;
	localparam logic [7:0] LEN_TRANSIT    = 8'd20;
	localparam logic [7:0] LEN_DESCRIPTOR = 8'd4;

	localparam logic [7:0] FLAG_RSV_MASK    = 8'h3f;
	localparam logic [7:0] TRANSIT_RSV_MASK = 8'h7f;

	localparam logic [2:0] KIND_NONE       = 3'd0;
	localparam logic [2:0] KIND_TARGET     = 3'd1;
	localparam logic [2:0] KIND_TRANSIT    = 3'd2;
	localparam logic [2:0] KIND_DESCRIPTOR = 3'd3;
	localparam logic [2:0] KIND_SIGNATURE  = 3'd4;

	localparam logic [1:0] PHASE_TYPE   = 2'd0;
	localparam logic [1:0] PHASE_LENGTH = 2'd1;
	localparam logic [1:0] PHASE_BODY   = 2'd2;

	localparam logic CFG_SIG_TYPE = 1'b0;
	localparam logic CFG_SIG_LEN  = 1'b1;

	localparam logic [7:0] SIG_TYPE_RESET = 8'd16;
	localparam logic [7:0] SIG_LEN_RESET  = 8'd64;

endpackage

// File: design/dmv_header.sv
// header field capture: instance, flags, sequence and dodag id
module dmv_header import dmv_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic       last,
	input  logic [7:0] data,
	output hdr_info_t  info
);

	logic [4:0]  pos_q, pos_n;
	logic [7:0]  inst_q, inst_n;
	logic        ack_q, ack_n;
	logic        idf_q, idf_n;
	logic        rsv_q, rsv_n;
	logic [7:0]  seq_q, seq_n;
	logic [63:0] upper_q, upper_n;
	logic [63:0] lower_q, lower_n;
	logic        active;

	assign active = (pos_q < HDR_SHORT) || (idf_q && (pos_q < HDR_LONG));

	always_comb begin
		pos_n   = pos_q;
		inst_n  = inst_q;
		ack_n   = ack_q;
		idf_n   = idf_q;
		rsv_n   = rsv_q;
		seq_n   = seq_q;
		upper_n = upper_q;
		lower_n = lower_q;
		if (active) begin
			pos_n = pos_q + 5'd1;
			unique case (pos_q)
				5'd0: inst_n = data;
				5'd1: begin
					ack_n = data[7];
					idf_n = data[6];
					if ((data & FLAG_RSV_MASK) != 8'd0) rsv_n = 1'b1;
				end
				5'd2: if (data != 8'd0) rsv_n = 1'b1;
				5'd3: seq_n = data;
				default: begin
					if (pos_q < HDR_UPPER) upper_n = {upper_q[55:0], data};
					else lower_n = {lower_q[55:0], data};
				end
			endcase
		end
	end

	always_comb begin
		info.active          = active;
		info.too_short       = pos_n < HDR_SHORT;
		info.id_short        = idf_n && (pos_n < HDR_LONG);
		info.reserved_fault  = rsv_n;
		info.instance_id     = inst_n;
		info.ack_flag        = ack_n;
		info.id_flag         = idf_n;
		info.sequence_number = seq_n;
		info.dodag_upper     = upper_n;
		info.dodag_lower     = lower_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			inst_q  <= '0;
			ack_q   <= 1'b0;
			idf_q   <= 1'b0;
			rsv_q   <= 1'b0;
			seq_q   <= '0;
			upper_q <= '0;
			lower_q <= '0;
		end else if (step) begin
			if (last) begin
				pos_q   <= '0;
				inst_q  <= '0;
				ack_q   <= 1'b0;
				idf_q   <= 1'b0;
				rsv_q   <= 1'b0;
				seq_q   <= '0;
				upper_q <= '0;
				lower_q <= '0;
			end else begin
				pos_q   <= pos_n;
				inst_q  <= inst_n;
				ack_q   <= ack_n;
				idf_q   <= idf_n;
				rsv_q   <= rsv_n;
				seq_q   <= seq_n;
				upper_q <= upper_n;
				lower_q <= lower_n;
			end
		end
	end

endmodule

// File: design/dmv_options.sv
// option walker: type, length and body checks
module dmv_options import dmv_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic       last,
	input  logic       hdr_active,
	input  logic [7:0] data,
	input  logic [7:0] sig_type,
	input  logic [7:0] sig_len,
	output opt_info_t  info
);

	logic [1:0] phase_q, phase_n;
	logic [2:0] kind_q, kind_n;
	logic [7:0] rem_q, rem_n;
	logic       sig_q, sig_n;
	logic       fault_q, fault_n;
	logic       work;
	logic [7:0] req_len;
	logic [7:0] rem_dec;

	function automatic logic [2:0] classify(input logic [7:0] b, input logic [7:0] code);
		logic [2:0] k;
		k = KIND_NONE;
		if (b == TYPE_TARGET) k = KIND_TARGET;
		else if (b == TYPE_TRANSIT) k = KIND_TRANSIT;
		else if (b == TYPE_DESCRIPTOR) k = KIND_DESCRIPTOR;
		else if (b == code) k = KIND_SIGNATURE;
		return k;
	endfunction

	assign work = !hdr_active && !fault_q;

	always_comb begin
		priority if (kind_q == KIND_TARGET) req_len = LEN_TARGET;
		else if (kind_q == KIND_TRANSIT) req_len = LEN_TRANSIT;
		else if (kind_q == KIND_DESCRIPTOR) req_len = LEN_DESCRIPTOR;
		else req_len = sig_len;
	end

	assign rem_dec = (rem_q != 8'd0) ? rem_q - 8'd1 : rem_q;

	always_comb begin
		phase_n = phase_q;
		kind_n  = kind_q;
		rem_n   = rem_q;
		sig_n   = sig_q;
		fault_n = fault_q;
		if (work) begin
			unique case (phase_q)
				PHASE_TYPE: begin
					if (sig_q) begin
						fault_n = 1'b1;
					end else if (data != TYPE_PAD1) begin
						kind_n = classify(data, sig_type);
						if (kind_n == KIND_NONE) begin
							fault_n = 1'b1;
						end else begin
							if (kind_n == KIND_SIGNATURE) sig_n = 1'b1;
							phase_n = PHASE_LENGTH;
						end
					end
				end
				PHASE_LENGTH: begin
					if (data != req_len) begin
						fault_n = 1'b1;
					end else begin
						rem_n   = data;
						phase_n = (data != 8'd0) ? PHASE_BODY : PHASE_TYPE;
					end
				end
				default: begin
					if (kind_q == KIND_TARGET && rem_q == LEN_TARGET && data != 8'd0)
						fault_n = 1'b1;
					if (kind_q == KIND_TRANSIT && rem_q == LEN_TRANSIT &&
					    (data & TRANSIT_RSV_MASK) != 8'd0)
						fault_n = 1'b1;
					rem_n = rem_dec;
					if (rem_dec == 8'd0) phase_n = PHASE_TYPE;
				end
			endcase
		end
	end

	assign info.fault       = fault_n;
	assign info.open_option = phase_n != PHASE_TYPE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PHASE_TYPE;
			kind_q  <= KIND_NONE;
			rem_q   <= '0;
			sig_q   <= 1'b0;
			fault_q <= 1'b0;
		end else if (step) begin
			if (last) begin
				phase_q <= PHASE_TYPE;
				kind_q  <= KIND_NONE;
				rem_q   <= '0;
				sig_q   <= 1'b0;
				fault_q <= 1'b0;
			end else begin
				phase_q <= phase_n;
				kind_q  <= kind_n;
				rem_q   <= rem_n;
				sig_q   <= sig_n;
				fault_q <= fault_n;
			end
		end
	end

endmodule

// File: design/dao_message_validator.sv
// top level of the dao message validator
//
// byte channel: byte_valid / byte_ready / byte_data carry one message byte per
// transfer, with final_byte set on the last byte of a message.
// result channel: result_valid / result_ready / result_data carry one result
// per message, produced for the transfer that holds the final byte.
// configuration: cfg_we writes cfg_data into register cfg_index
// (0 signature type code, 1 signature body length).
// a final byte is held in the input register, then its result is registered.
// throughput: one byte per cycle unless stalled; an input register feeds the
// header and option parse logic, which update their state and fill the result
// register. the result register frees itself in the cycle it is taken, so
// there are no gaps while the receiver keeps result_ready high.
// receiver stall: a held result blocks only a second final byte; other bytes
// keep flowing through the parse state.
// reset: clears the input and result stages, the parse state and returns the
// configuration registers to type 16 and length 64.
module dao_message_validator import dmv_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       byte_valid,
	output logic       byte_ready,
	input  in_item_t   byte_data,
	output logic       result_valid,
	input  logic       result_ready,
	output out_item_t  result_data,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [7:0] cfg_data
);

	logic       valid_s1;
	in_item_t   item_s1;
	logic [7:0] sig_type_q;
	logic [7:0] sig_len_q;
	logic       out_valid_q;
	out_item_t  out_q;
	logic       advance;
	logic       step;
	logic       emit;
	hdr_info_t  hdr;
	opt_info_t  opt;
	out_item_t  res;

	assign advance    = !item_s1.final_byte || !out_valid_q || result_ready;
	assign step       = valid_s1 && advance;
	assign emit       = step && item_s1.final_byte;
	assign byte_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ready) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_ready && byte_valid) item_s1 <= byte_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sig_type_q <= SIG_TYPE_RESET;
			sig_len_q  <= SIG_LEN_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SIG_TYPE: sig_type_q <= cfg_data;
				CFG_SIG_LEN:  sig_len_q  <= cfg_data;
			endcase
		end
	end

	dmv_header u_header (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.last   (item_s1.final_byte),
		.data   (item_s1.msg_byte),
		.info   (hdr)
	);

	dmv_options u_options (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.last       (item_s1.final_byte),
		.hdr_active (hdr.active),
		.data       (item_s1.msg_byte),
		.sig_type   (sig_type_q),
		.sig_len    (sig_len_q),
		.info       (opt)
	);

	always_comb begin
		res = '0;
		priority if (hdr.too_short) res.status = ST_TOO_SHORT;
		else if (hdr.reserved_fault) res.status = ST_BAD;
		else if (hdr.id_short) res.status = ST_TOO_SHORT;
		else if (opt.fault || opt.open_option) res.status = ST_BAD;
		else res.status = ST_OK;
		if (res.status == ST_OK) begin
			res.instance_id     = hdr.instance_id;
			res.ack_wanted      = hdr.ack_flag;
			res.id_present      = hdr.id_flag;
			res.sequence_number = hdr.sequence_number;
			res.dodag_id_high   = hdr.id_flag ? hdr.dodag_upper : 64'd0;
			res.dodag_id_low    = hdr.id_flag ? hdr.dodag_lower : 64'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) out_q <= res;
	end

	assign result_valid = out_valid_q;
	assign result_data  = out_q;

endmodule
